// ===== rtl/plt_pkg.sv =====
// Package for the positional list table: sizes, command codes and the
// control struct that the top level broadcasts to the row of entry cells.
// No dependencies.
package plt_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // compare width: holds any position, any count and count + 1
    localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_INSERT = 2'd2,
        MODE_DELETE = 2'd3
    } t_mode;

    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

// ===== rtl/plt_if.sv =====
// Channel interfaces of the positional list table: command and response,
// each valid/ready with its payload. Depends on plt_pkg.
interface plt_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          mode;
    logic [plt_pkg::POS_W-1:0]           position;
    logic signed [plt_pkg::DATA_W-1:0]   value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface plt_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic signed [plt_pkg::DATA_W-1:0]   read_value;
    logic [plt_pkg::POS_W-1:0]           found_position;
    logic [plt_pkg::POS_W-1:0]           length;

    modport source (output valid, output ok, output read_value, output found_position,
                    output length, input ready);
    modport sink   (input valid, input ok, input read_value, input found_position,
                    input length, output ready);
endinterface

// ===== rtl/positional_list_table.sv =====
// Top level of the positional list table: command decode, count register,
// row of plt_cell entries, read mux, first-match search, response register.
// Depends on plt_pkg, plt_if (plt_cmd_if, plt_rsp_if) and plt_cell.
//
// Usage:
//   i_cmd carries one command item (mode, position, value); o_rsp returns
//   exactly one response item (ok, read_value, found_position, length) per
//   command, in order. Both channels move an item when valid and ready are
//   high at a rising edge of i_clk.
//   The response is registered and valid the cycle after the command is taken.
//   Throughput: one command per cycle unless the response receiver stalls.
//   Every cell shifts or compares in the same cycle; the cycle is set by the
//   16-way read mux and the first-match priority search over the cell row.
//   i_cmd.ready is high while the response register is empty or being taken,
//   so a stalled receiver holds the response and blocks new commands.
//   Reset (i_rst_n low, synchronous) empties the list and the response
//   register; entry words are not cleared, positions above length are never
//   read.
module positional_list_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plt_cmd_if.sink     i_cmd,
    plt_rsp_if.source   o_rsp
);

    localparam int CAP = plt_pkg::CAPACITY;

    logic [plt_pkg::CNT_W-1:0]          r_count;
    logic [plt_pkg::CNT_W-1:0]          n_count;
    logic                               r_valid;
    logic                               r_ok;
    logic signed [plt_pkg::DATA_W-1:0]  r_read_value;
    logic [plt_pkg::POS_W-1:0]          r_found_position;
    logic [plt_pkg::POS_W-1:0]          r_length;

    logic                               cmd_fire;
    plt_pkg::t_mode                     mode;
    logic [plt_pkg::CMP_W-1:0]          pos_x;
    logic [plt_pkg::CMP_W-1:0]          cnt_x;
    logic                               in_range;
    logic                               ins_ok;
    logic [plt_pkg::IDX_W-1:0]          rd_idx;
    logic                               hit;
    logic [plt_pkg::IDX_W-1:0]          hit_idx;
    logic                               res_ok;
    logic signed [plt_pkg::DATA_W-1:0]  res_read;
    logic [plt_pkg::POS_W-1:0]          res_found;
    plt_pkg::t_cell_ctl                 cell_ctl;

    logic signed [plt_pkg::DATA_W-1:0]  w_entry [CAP];
    logic [CAP-1:0]                     w_match;

    assign i_cmd.ready = !r_valid || o_rsp.ready;
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;
    assign mode        = plt_pkg::t_mode'(i_cmd.mode);

    assign pos_x    = plt_pkg::CMP_W'(i_cmd.position);
    assign cnt_x    = plt_pkg::CMP_W'(r_count);
    assign in_range = (i_cmd.position != '0) && (pos_x <= cnt_x);
    assign ins_ok   = (i_cmd.position != '0) && (pos_x <= cnt_x + plt_pkg::CMP_W'(1))
                      && (cnt_x < plt_pkg::CMP_W'(CAP));
    assign rd_idx   = plt_pkg::IDX_W'(pos_x - plt_pkg::CMP_W'(1));

    assign cell_ctl.ins   = cmd_fire && (mode == plt_pkg::MODE_INSERT) && ins_ok;
    assign cell_ctl.del   = cmd_fire && (mode == plt_pkg::MODE_DELETE) && in_range;
    assign cell_ctl.pos   = i_cmd.position;
    assign cell_ctl.value = i_cmd.value;

    // row of cells; each takes its left or right neighbor on a shift
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic signed [plt_pkg::DATA_W-1:0] prev_w;
        logic signed [plt_pkg::DATA_W-1:0] next_w;
        if (g == 0) begin : g_first
            assign prev_w = '0;
        end else begin : g_mid
            assign prev_w = w_entry[g-1];
        end
        if (g == CAP - 1) begin : g_last
            assign next_w = w_entry[g];
        end else begin : g_inner
            assign next_w = w_entry[g+1];
        end
        plt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_index (plt_pkg::IDX_W'(g)),
            .i_prev  (prev_w),
            .i_next  (next_w),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    // lowest occupied matching cell wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = CAP - 1; i >= 0; i--) begin
            if (w_match[i] && (plt_pkg::CNT_W'(i) < r_count)) begin
                hit     = 1'b1;
                hit_idx = plt_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_count   = r_count;
        res_ok    = 1'b0;
        res_read  = '0;
        res_found = '0;
        unique case (mode)
            plt_pkg::MODE_READ: begin
                if (in_range) begin
                    res_ok   = 1'b1;
                    res_read = w_entry[rd_idx];
                end
            end
            plt_pkg::MODE_FIND: begin
                if (hit) begin
                    res_ok    = 1'b1;
                    res_found = plt_pkg::POS_W'(plt_pkg::CMP_W'(hit_idx) + plt_pkg::CMP_W'(1));
                end
            end
            plt_pkg::MODE_INSERT: begin
                if (ins_ok) begin
                    res_ok  = 1'b1;
                    n_count = r_count + plt_pkg::CNT_W'(1);
                end
            end
            plt_pkg::MODE_DELETE: begin
                if (in_range) begin
                    res_ok  = 1'b1;
                    n_count = r_count - plt_pkg::CNT_W'(1);
                end
            end
            default: begin
                res_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (cmd_fire) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_ok             <= res_ok;
            r_read_value     <= res_read;
            r_found_position <= res_found;
            r_length         <= plt_pkg::POS_W'(n_count);
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.ok             = r_ok;
    assign o_rsp.read_value     = r_read_value;
    assign o_rsp.found_position = r_found_position;
    assign o_rsp.length         = r_length;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        plt_pkg::CMP_W'(r_count) <= plt_pkg::CMP_W'(CAP))
        else $error("list count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctl.ins |=> (r_count == $past(r_count) + plt_pkg::CNT_W'(1)))
        else $error("accepted insert did not grow the list");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_ok) |-> (r_read_value == '0 && r_found_position == '0))
        else $error("refused command reports nonzero data");

    a_length_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_fire |=> (r_length == plt_pkg::POS_W'(r_count)))
        else $error("reported length differs from count");

endmodule

// ===== rtl/plt_cell.sv =====
// One entry cell of the list: holds a word, shifts toward either neighbor
// on insert/delete, and flags a match against the search word.
// Depends on plt_pkg.
module plt_cell (
    input  logic                               i_clk,
    input  plt_pkg::t_cell_ctl                 i_ctl,
    input  logic [plt_pkg::IDX_W-1:0]          i_index,
    input  logic signed [plt_pkg::DATA_W-1:0]  i_prev,
    input  logic signed [plt_pkg::DATA_W-1:0]  i_next,
    output logic signed [plt_pkg::DATA_W-1:0]  o_entry,
    output logic                               o_match
);

    logic signed [plt_pkg::DATA_W-1:0] r_entry;
    logic signed [plt_pkg::DATA_W-1:0] n_entry;
    logic [plt_pkg::CMP_W-1:0]         cell_pos;
    logic [plt_pkg::CMP_W-1:0]         cmd_pos;

    // 1-based position of this cell
    assign cell_pos = plt_pkg::CMP_W'(i_index) + plt_pkg::CMP_W'(1);
    assign cmd_pos  = plt_pkg::CMP_W'(i_ctl.pos);

    // insert and delete never fire together; with neither the word holds
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (cell_pos == cmd_pos) begin
                n_entry = i_ctl.value;
            end else if (cell_pos > cmd_pos) begin
                n_entry = i_prev;
            end
        end else if (i_ctl.del) begin
            if (cell_pos >= cmd_pos) begin
                n_entry = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_ctl.value);

endmodule

// ===== verif/plt_list_checker.sv =====
// Response checker for the positional list table: keeps its own copy of the
// list, predicts one response per accepted command and compares in order.
// Depends on plt_pkg.
module plt_list_checker
    import plt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  logic                     i_cmd_ready,
    input  logic [1:0]               i_cmd_mode,
    input  logic [POS_W-1:0]         i_cmd_position,
    input  logic signed [DATA_W-1:0] i_cmd_value,
    input  logic                     i_rsp_valid,
    input  logic                     i_rsp_ready,
    input  logic                     i_rsp_ok,
    input  logic signed [DATA_W-1:0] i_rsp_read_value,
    input  logic [POS_W-1:0]         i_rsp_found_position,
    input  logic [POS_W-1:0]         i_rsp_length,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         length;
    } t_table_rsp;

    logic signed [DATA_W-1:0] list_words [CAPACITY];
    int                       list_len;
    t_table_rsp               expected_rsps [$];
    t_table_rsp               want;
    t_table_rsp               got;
    int                       mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_rsps.size();

    initial begin
        mismatches = 0;
        list_len   = 0;
        foreach (list_words[k]) list_words[k] = '0;
    end

    // Applies one command to the shadow list and returns its response.
    function automatic t_table_rsp apply_command(t_mode mode, logic [POS_W-1:0] position,
                                                 logic signed [DATA_W-1:0] value);
        t_table_rsp r;
        int         pos;
        int         k;
        r   = '0;
        pos = int'(position);
        case (mode)
            MODE_READ: begin
                if (pos >= 1 && pos <= list_len) begin
                    r.ok         = 1'b1;
                    r.read_value = list_words[pos-1];
                end
            end
            MODE_FIND: begin
                // lowest matching position wins
                for (k = 0; k < list_len; k++) begin
                    if (!r.ok && list_words[k] == value) begin
                        r.ok             = 1'b1;
                        r.found_position = POS_W'(k + 1);
                    end
                end
            end
            MODE_INSERT: begin
                if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) begin
                    for (k = list_len; k >= pos; k--) list_words[k] = list_words[k-1];
                    list_words[pos-1] = value;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            default: begin
                if (pos >= 1 && pos <= list_len) begin
                    for (k = pos; k < list_len; k++) list_words[k-1] = list_words[k];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
        endcase
        r.length = POS_W'(list_len);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            expected_rsps.delete();
        end else begin
            // a response taken now belongs to an earlier command, so check first
            if (i_rsp_valid && i_rsp_ready) begin
                got = '{i_rsp_ok, i_rsp_read_value, i_rsp_found_position, i_rsp_length};
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response, expected none, got %h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (got.ok !== want.ok) begin
                        $display("%0t: ok mismatch, expected %0d, got %0d",
                                 $time, want.ok, got.ok);
                        mismatches++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $display("%0t: read_value mismatch, expected %0d, got %0d",
                                 $time, want.read_value, got.read_value);
                        mismatches++;
                    end
                    if (got.found_position !== want.found_position) begin
                        $display("%0t: found_position mismatch, expected %0d, got %0d",
                                 $time, want.found_position, got.found_position);
                        mismatches++;
                    end
                    if (got.length !== want.length) begin
                        $display("%0t: length mismatch, expected %0d, got %0d",
                                 $time, want.length, got.length);
                        mismatches++;
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                expected_rsps.push_back(apply_command(t_mode'(i_cmd_mode), i_cmd_position,
                                                      i_cmd_value));
            end
        end
    end

endmodule

// ===== verif/tb_positional_list_table.sv =====
// Testbench top for the positional list table: clock, reset, command stimulus
// and response backpressure; checking is done by plt_list_checker.
// Depends on plt_pkg, plt_if, positional_list_table and plt_list_checker.
module tb_positional_list_table;
    import plt_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int PHASE_ITEMS  = 48;
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    int   list_len = 0;   // stimulus-side length, used only to aim positions
    bit   no_idle = 1'b0;
    int   sent = 0;
    int   phase_kind;

    plt_cmd_if cmd_ch ();
    plt_rsp_if rsp_ch ();

    positional_list_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    plt_list_checker u_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd_valid          (cmd_ch.valid),
        .i_cmd_ready          (cmd_ch.ready),
        .i_cmd_mode           (cmd_ch.mode),
        .i_cmd_position       (cmd_ch.position),
        .i_cmd_value          (cmd_ch.value),
        .i_rsp_valid          (rsp_ch.valid),
        .i_rsp_ready          (rsp_ch.ready),
        .i_rsp_ok             (rsp_ch.ok),
        .i_rsp_read_value     (rsp_ch.read_value),
        .i_rsp_found_position (rsp_ch.found_position),
        .i_rsp_length         (rsp_ch.length),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int draw_wait();
        if (no_idle) return 0;
        return $urandom_range(0, 9);
    endfunction

    // Four draws in ten come from a small pool so finds hit and duplicates pile up.
    function automatic logic signed [DATA_W-1:0] draw_value();
        if ($urandom_range(0, 9) < 4) begin
            case ($urandom_range(0, 7))
                0: return 32'sh0000_0000;
                1: return -32'sd1;
                2: return 32'sh8000_0000;
                3: return 32'sh7FFF_FFFF;
                4: return 32'sd1;
                5: return 32'sd42;
                6: return -32'sd7;
                default: return 32'sd5;
            endcase
        end
        return $urandom;
    endfunction

    // Presents one command after a random gap and holds it until taken.
    task automatic send_cmd(t_mode mode, logic [POS_W-1:0] position,
                            logic signed [DATA_W-1:0] value);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.mode     <= mode;
        cmd_ch.position <= position;
        cmd_ch.value    <= value;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (mode == MODE_INSERT && position >= 1 && position <= list_len + 1
                && list_len < CAPACITY)
            list_len++;
        else if (mode == MODE_DELETE && position >= 1 && position <= list_len)
            list_len--;
    endtask

    // kind 0 leans to inserts (fills the list), 1 to deletes, 2 is even.
    task automatic send_random_cmd(int kind);
        int               roll;
        int               ins_share;
        int               del_share;
        t_mode            mode;
        logic [POS_W-1:0] position;
        roll      = $urandom_range(0, 99);
        ins_share = (kind == 0) ? 55 : (kind == 1) ? 15 : 25;
        del_share = (kind == 1) ? 55 : (kind == 0) ? 15 : 25;
        if (roll < ins_share)                   mode = MODE_INSERT;
        else if (roll < ins_share + del_share)  mode = MODE_DELETE;
        else if (roll < ins_share + del_share + (100 - ins_share - del_share) / 2)
            mode = MODE_READ;
        else
            mode = MODE_FIND;
        if ($urandom_range(0, 9) == 0 || mode == MODE_FIND)
            position = POS_W'($urandom_range(0, 31));
        else if (mode == MODE_INSERT)
            position = POS_W'($urandom_range(1, list_len + 1));
        else if (list_len == 0)
            position = POS_W'($urandom_range(0, 2));
        else
            position = POS_W'($urandom_range(1, list_len));
        send_cmd(mode, position, draw_value());
    endtask

    // Response side: a random stall before each item, then ready until taken.
    initial begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.mode     <= MODE_READ;
        cmd_ch.position <= '0;
        cmd_ch.value    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, refusals, extremes, zero entry, duplicates
        send_cmd(MODE_READ,   5'd1,  32'sd0);
        send_cmd(MODE_FIND,   5'd0,  32'sd0);
        send_cmd(MODE_DELETE, 5'd1,  32'sd0);
        send_cmd(MODE_INSERT, 5'd0,  32'sd5);
        send_cmd(MODE_INSERT, 5'd2,  32'sd5);
        send_cmd(MODE_INSERT, 5'd1,  32'sh8000_0000);
        send_cmd(MODE_INSERT, 5'd2,  32'sh7FFF_FFFF);
        send_cmd(MODE_INSERT, 5'd1,  32'sd0);
        send_cmd(MODE_INSERT, 5'd4,  -32'sd1);
        send_cmd(MODE_INSERT, 5'd31, 32'sd9);
        send_cmd(MODE_READ,   5'd1,  32'sd0);
        send_cmd(MODE_READ,   5'd0,  32'sd0);
        send_cmd(MODE_READ,   5'd31, 32'sd0);
        send_cmd(MODE_READ,   5'd4,  32'sd0);
        send_cmd(MODE_READ,   5'd5,  32'sd0);
        send_cmd(MODE_FIND,   5'd31, 32'sh7FFF_FFFF);
        send_cmd(MODE_FIND,   5'd3,  32'sd12345);
        send_cmd(MODE_INSERT, 5'd2,  -32'sd1);
        send_cmd(MODE_FIND,   5'd0,  -32'sd1);
        send_cmd(MODE_DELETE, 5'd0,  32'sd0);
        send_cmd(MODE_DELETE, 5'd31, 32'sd0);
        send_cmd(MODE_DELETE, 5'd6,  32'sd0);
        send_cmd(MODE_DELETE, 5'd5,  32'sd0);
        send_cmd(MODE_DELETE, 5'd1,  32'sd0);
        send_cmd(MODE_FIND,   5'd1,  32'sd0);

        while (sent < RANDOM_ITEMS) begin
            phase_kind = $urandom_range(0, 2);
            no_idle    = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) begin
                send_random_cmd(phase_kind);
                sent++;
            end
        end
        no_idle      = 1'b0;
        cmd_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
